[src/acp_pkg.sv]
package acp_pkg;

    typedef logic [2:0] mac_cmd_t;

    localparam mac_cmd_t MAC_NONE    = 3'd0;
    localparam mac_cmd_t MAC_LOAD    = 3'd1;
    localparam mac_cmd_t MAC_ADD     = 3'd2;
    localparam mac_cmd_t MAC_ADD_SHR = 3'd3;
    localparam mac_cmd_t MAC_ADD_SHL = 3'd4;

    localparam logic [3:0] REQ_TICK    = 4'd0;
    localparam logic [3:0] REQ_ENABLE  = 4'd1;
    localparam logic [3:0] REQ_DISABLE = 4'd2;
    localparam logic [3:0] REQ_CANCEL  = 4'd3;
    localparam logic [3:0] REQ_RESUME  = 4'd4;
    localparam logic [3:0] REQ_PLUS10  = 4'd5;
    localparam logic [3:0] REQ_PLUS5   = 4'd6;
    localparam logic [3:0] REQ_MINUS10 = 4'd7;
    localparam logic [3:0] REQ_MINUS5  = 4'd8;
    localparam logic [3:0] REQ_GAP     = 4'd9;

    localparam logic [2:0] CFG_SPEED_P = 3'd0;
    localparam logic [2:0] CFG_SPEED_I = 3'd1;
    localparam logic [2:0] CFG_SPEED_D = 3'd2;
    localparam logic [2:0] CFG_GAP_P   = 3'd3;
    localparam logic [2:0] CFG_GAP_I   = 3'd4;
    localparam logic [2:0] CFG_GAP_D   = 3'd5;
    localparam logic [2:0] CFG_ACCEL   = 3'd6;
    localparam logic [2:0] CFG_DECEL   = 3'd7;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_SPEED = 2'd1;
    localparam logic [1:0] MODE_GAP   = 2'd2;

    localparam logic signed [18:0] CAR_LEN    = 19'sd1280;
    localparam logic signed [18:0] FIFTY_M    = 19'sd12800;
    localparam logic signed [21:0] SPEED_MAX  = 22'sd131071;
    localparam logic signed [11:0] DIV_OFFSET = 12'sd1000;
    localparam logic [15:0]        RECIP5     = 16'd52429;

endpackage

[src/acp_mac.sv]
module acp_mac
    import acp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [24:0]  op_a,
    input  logic signed [24:0]  op_b,
    input  mac_cmd_t            cmd,
    output logic signed [59:0]  acc
);

    logic signed [49:0] prod_reg;
    mac_cmd_t           cmd_reg;
    logic signed [59:0] acc_reg;
    logic signed [59:0] acc_next;
    logic signed [59:0] prod_ext;

    assign prod_ext = {{10{prod_reg[49]}}, prod_reg};

    always_comb
    begin
        unique case (cmd_reg)
            MAC_LOAD:    acc_next = prod_ext;
            MAC_ADD:     acc_next = acc_reg + prod_ext;
            MAC_ADD_SHR: acc_next = acc_reg + (prod_ext >>> 16);
            MAC_ADD_SHL: acc_next = acc_reg + (prod_ext <<< 8);
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= MAC_NONE;
        end
        else
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[src/adaptive_cruise_pid_controller_core.sv]
// A button or passthrough item goes from dispatch to output (a speed step via divide and
// step); an active tick runs the speed PID pass, then the distance pass when that loop runs.
// Throughput: one item at a time; each PID pass is 7 steps of the single shared 25x25
// multiplier. A finished result waits in the output register while the next item enters.
// Reset clears all flags, the target speed, the gap mode, both integrals and both
// previous errors, and loads the gain and limit registers with their defaults.
module adaptive_cruise_pid_controller_core
    import acp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          req_type,
    input  logic signed [17:0]  ego_speed,
    input  logic                lead_present,
    input  logic [17:0]         lead_distance,
    input  logic signed [17:0]  lead_rel_speed,
    input  logic                driver_present,
    input  logic signed [14:0]  driver_accel,
    input  logic [15:0]         step_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accel_valid,
    output logic signed [14:0]  accel_cmd,
    output logic [1:0]          loop_mode,
    output logic                is_enabled,
    output logic                is_active,
    output logic                set_speed_valid,
    output logic signed [17:0]  set_speed,
    output logic [1:0]          gap_mode
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_P0    = 4'd4;
    localparam logic [3:0] S_P1    = 4'd5;
    localparam logic [3:0] S_P2    = 4'd6;
    localparam logic [3:0] S_P3    = 4'd7;
    localparam logic [3:0] S_P4    = 4'd8;
    localparam logic [3:0] S_P5    = 4'd9;
    localparam logic [3:0] S_P6    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    logic [23:0] spd_kp_reg, spd_ki_reg, spd_kd_reg;
    logic [23:0] gap_kp_reg, gap_ki_reg, gap_kd_reg;
    logic [13:0] accel_lim_reg, decel_lim_reg;

    logic [3:0]         req_reg;
    logic signed [17:0] ego_reg;
    logic               lead_reg;
    logic [17:0]        dist_reg;
    logic signed [17:0] rel_reg;
    logic               drv_reg;
    logic signed [14:0] dacc_reg;
    logic [15:0]        dt_reg;

    logic               en_reg, en_next;
    logic               act_reg, act_next;
    logic               held_reg, held_next;
    logic signed [17:0] tgt_reg, tgt_next;
    logic [1:0]         gmode_reg, gmode_next;
    logic signed [47:0] s_int_reg, s_int_next;
    logic signed [19:0] s_prev_reg, s_prev_next;
    logic signed [47:0] g_int_reg, g_int_next;
    logic signed [19:0] g_prev_reg, g_prev_next;

    logic               sel_reg, sel_next;
    logic               gap_go_reg, gap_go_next;
    logic signed [19:0] dev_reg, dev_next;
    logic signed [19:0] e_reg, e_next;
    logic signed [47:0] i_reg, i_next;
    logic signed [43:0] res_reg, res_next;
    logic               wk_valid_reg, wk_valid_next;
    logic [1:0]         wk_mode_reg, wk_mode_next;
    logic signed [9:0]  q_reg, q_next;

    logic               out_valid_reg, out_valid_next;
    logic               o_av_reg;
    logic signed [14:0] o_cmd_reg;
    logic [1:0]         o_mode_reg;
    logic               o_en_reg, o_act_reg, o_held_reg;
    logic signed [17:0] o_spd_reg;
    logic [1:0]         o_gmode_reg;
    logic               out_load;

    logic signed [24:0] op_a, op_b;
    mac_cmd_t           mac_cmd;
    logic signed [59:0] acc;

    logic signed [18:0] ego_ext, ego_half, gap_c;
    logic signed [19:0] dev_c;
    logic signed [22:0] dev5_c;
    logic signed [18:0] spd_sum_c;
    logic               gap_go_c;
    logic signed [19:0] serr_c;

    logic               up_c, k10_c;
    logic signed [18:0] t_adj_c;
    logic signed [11:0] n_c;
    logic [26:0]        prod_c;
    logic [8:0]         qn_c;
    logic signed [10:0] m_c;
    logic signed [21:0] y_c;
    logic signed [21:0] y_sat_c;

    logic [23:0]        kp_sel, ki_sel, kd_sel;
    logic signed [47:0] int_sel;
    logic signed [19:0] prev_sel;
    logic signed [20:0] d_c;
    logic signed [49:0] isum_c;
    logic signed [47:0] isat_c;
    logic signed [43:0] lim_hi, lim_lo;
    logic signed [14:0] clamp_c;

    acp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op_a  (op_a),
        .op_b  (op_b),
        .cmd   (mac_cmd),
        .acc   (acc)
    );

    // Target gap and the test for switching to the distance loop.
    assign ego_ext   = {ego_reg[17], ego_reg};
    assign ego_half  = ego_ext >>> 1;
    always_comb
    begin
        unique case (gmode_reg)
            2'd0:    gap_c = (ego_ext > CAR_LEN) ? ego_ext : CAR_LEN;
            2'd1:    gap_c = (ego_half > CAR_LEN) ? ego_half : CAR_LEN;
            2'd2:    gap_c = FIFTY_M;
            default: gap_c = CAR_LEN;
        endcase
    end
    assign dev_c     = signed'({2'b00, dist_reg}) - {gap_c[18], gap_c};
    assign dev5_c    = {{3{dev_c[19]}}, dev_c} + {dev_c[19], dev_c, 2'b00};
    assign spd_sum_c = ego_ext + {rel_reg[17], rel_reg};
    assign gap_go_c  = lead_reg && (dev5_c < $signed({{4{gap_c[18]}}, gap_c}))
                       && (spd_sum_c < $signed({tgt_reg[17], tgt_reg}));
    assign serr_c    = {{2{tgt_reg[17]}}, tgt_reg} - {{2{ego_reg[17]}}, ego_reg};

    // Target speed stepping to multiples of 5 or 10 km/h.
    assign up_c    = (req_reg == REQ_PLUS10) || (req_reg == REQ_PLUS5);
    assign k10_c   = (req_reg == REQ_PLUS10) || (req_reg == REQ_MINUS10);
    assign t_adj_c = up_c ? {tgt_reg[17], tgt_reg} : ({tgt_reg[17], tgt_reg} - 19'sd1);
    assign n_c     = {t_adj_c[18], t_adj_c[18:8]} + DIV_OFFSET;
    assign prod_c  = {16'd0, n_c[10:0]} * {11'd0, RECIP5};
    assign qn_c    = k10_c ? {1'b0, prod_c[26:19]} : prod_c[26:18];
    assign m_c     = {2'b00, qn_c} - (k10_c ? 11'sd100 : 11'sd200) + (up_c ? 11'sd1 : 11'sd0);
    assign y_c     = k10_c ? ({{9{q_reg[9]}}, q_reg, 3'b000} + {{11{q_reg[9]}}, q_reg, 1'b0})
                              <<< 8
                           : ({{10{q_reg[9]}}, q_reg, 2'b00} + {{12{q_reg[9]}}, q_reg}) <<< 8;
    always_comb
    begin
        priority if (up_c && (y_c > SPEED_MAX))
        begin
            y_sat_c = SPEED_MAX;
        end
        else if (!up_c && (y_c < 22'sd0))
        begin
            y_sat_c = 22'sd0;
        end
        else
        begin
            y_sat_c = y_c;
        end
    end

    // PID loop selection and integral update.
    assign kp_sel   = sel_reg ? gap_kp_reg : spd_kp_reg;
    assign ki_sel   = sel_reg ? gap_ki_reg : spd_ki_reg;
    assign kd_sel   = sel_reg ? gap_kd_reg : spd_kd_reg;
    assign int_sel  = sel_reg ? g_int_reg : s_int_reg;
    assign prev_sel = sel_reg ? g_prev_reg : s_prev_reg;
    assign d_c      = {e_reg[19], e_reg} - {prev_sel[19], prev_sel};
    assign isum_c   = {{2{int_sel[47]}}, int_sel} + acc[49:0];
    always_comb
    begin
        priority if ((isum_c[49:47] == 3'b000) || (isum_c[49:47] == 3'b111))
        begin
            isat_c = isum_c[47:0];
        end
        else if (!isum_c[49])
        begin
            isat_c = {1'b0, {47{1'b1}}};
        end
        else
        begin
            isat_c = {1'b1, 47'd0};
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_P0:
            begin
                op_a    = {9'd0, dt_reg};
                op_b    = {{5{e_reg[19]}}, e_reg};
                mac_cmd = MAC_LOAD;
            end
            S_P1:
            begin
                op_a    = {1'b0, kp_sel};
                op_b    = {{5{e_reg[19]}}, e_reg};
                mac_cmd = MAC_LOAD;
            end
            S_P2:
            begin
                op_a    = {1'b0, kd_sel};
                op_b    = {{4{d_c[20]}}, d_c};
                mac_cmd = MAC_ADD;
            end
            S_P3:
            begin
                op_a    = {1'b0, ki_sel};
                op_b    = {1'b0, i_reg[23:0]};
                mac_cmd = MAC_ADD_SHR;
            end
            S_P4:
            begin
                op_a    = {1'b0, ki_sel};
                op_b    = {i_reg[47], i_reg[47:24]};
                mac_cmd = MAC_ADD_SHL;
            end
            default:
            begin
                op_a    = 25'sd0;
                op_b    = 25'sd0;
                mac_cmd = MAC_NONE;
            end
        endcase
    end

    // Saturation of the loop output to the acceleration limits; passthrough values are not clamped.
    assign lim_hi = signed'({30'd0, accel_lim_reg});
    assign lim_lo = -signed'({30'd0, decel_lim_reg});
    always_comb
    begin
        priority if (wk_mode_reg == MODE_PASS)
        begin
            clamp_c = res_reg[14:0];
        end
        else if (res_reg > lim_hi)
        begin
            clamp_c = lim_hi[14:0];
        end
        else if (res_reg < lim_lo)
        begin
            clamp_c = lim_lo[14:0];
        end
        else
        begin
            clamp_c = res_reg[14:0];
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        en_next        = en_reg;
        act_next       = act_reg;
        held_next      = held_reg;
        tgt_next       = tgt_reg;
        gmode_next     = gmode_reg;
        s_int_next     = s_int_reg;
        s_prev_next    = s_prev_reg;
        g_int_next     = g_int_reg;
        g_prev_next    = g_prev_reg;
        sel_next       = sel_reg;
        gap_go_next    = gap_go_reg;
        dev_next       = dev_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        res_next       = res_reg;
        wk_valid_next  = wk_valid_reg;
        wk_mode_next   = wk_mode_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_next      = 44'sd0;
                wk_valid_next = 1'b0;
                wk_mode_next  = MODE_PASS;
                state_next    = S_OUT;
                unique case (req_reg)
                    REQ_TICK:
                    begin
                        if (!en_reg || !act_reg)
                        begin
                            if (drv_reg)
                            begin
                                wk_valid_next = 1'b1;
                                res_next      = {{29{dacc_reg[14]}}, dacc_reg};
                            end
                        end
                        else
                        begin
                            e_next        = serr_c;
                            dev_next      = dev_c;
                            gap_go_next   = gap_go_c;
                            sel_next      = 1'b0;
                            wk_valid_next = 1'b1;
                            wk_mode_next  = MODE_SPEED;
                            state_next    = S_P0;
                        end
                    end
                    REQ_ENABLE:
                    begin
                        if (!en_reg)
                        begin
                            en_next   = 1'b1;
                            act_next  = 1'b0;
                            held_next = 1'b0;
                            tgt_next  = 18'sd0;
                        end
                    end
                    REQ_DISABLE: en_next = 1'b0;
                    REQ_CANCEL:  act_next = 1'b0;
                    REQ_RESUME:
                    begin
                        act_next = 1'b1;
                        if (!held_reg)
                        begin
                            held_next = 1'b1;
                            tgt_next  = ego_reg;
                        end
                    end
                    REQ_PLUS10, REQ_PLUS5, REQ_MINUS10, REQ_MINUS5:
                    begin
                        if (!held_reg)
                        begin
                            held_next = 1'b1;
                            tgt_next  = ego_reg;
                        end
                        state_next = S_DIV;
                    end
                    REQ_GAP: gmode_next = gmode_reg + 2'd1;
                    default: state_next = S_OUT;
                endcase
            end
            S_DIV:
            begin
                q_next     = m_c[9:0];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                tgt_next   = y_sat_c[17:0];
                state_next = S_OUT;
            end
            S_P0: state_next = S_P1;
            S_P1: state_next = S_P2;
            S_P2:
            begin
                i_next     = isat_c;
                state_next = S_P3;
            end
            S_P3: state_next = S_P4;
            S_P4: state_next = S_P5;
            S_P5: state_next = S_P6;
            S_P6:
            begin
                res_next = acc[59:16];
                if (sel_reg)
                begin
                    g_int_next  = i_reg;
                    g_prev_next = e_reg;
                end
                else
                begin
                    s_int_next  = i_reg;
                    s_prev_next = e_reg;
                end
                if (!sel_reg && gap_go_reg)
                begin
                    sel_next     = 1'b1;
                    e_next       = dev_reg;
                    wk_mode_next = MODE_GAP;
                    state_next   = S_P0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            en_reg        <= 1'b0;
            act_reg       <= 1'b0;
            held_reg      <= 1'b0;
            tgt_reg       <= 18'sd0;
            gmode_reg     <= 2'd0;
            s_int_reg     <= 48'sd0;
            s_prev_reg    <= 20'sd0;
            g_int_reg     <= 48'sd0;
            g_prev_reg    <= 20'sd0;
            sel_reg       <= 1'b0;
            gap_go_reg    <= 1'b0;
            wk_valid_reg  <= 1'b0;
            wk_mode_reg   <= MODE_PASS;
            out_valid_reg <= 1'b0;
            spd_kp_reg    <= 24'd65536;
            spd_ki_reg    <= 24'd0;
            spd_kd_reg    <= 24'd0;
            gap_kp_reg    <= 24'd65536;
            gap_ki_reg    <= 24'd0;
            gap_kd_reg    <= 24'd0;
            accel_lim_reg <= 14'd768;
            decel_lim_reg <= 14'd2048;
        end
        else
        begin
            state_reg     <= state_next;
            en_reg        <= en_next;
            act_reg       <= act_next;
            held_reg      <= held_next;
            tgt_reg       <= tgt_next;
            gmode_reg     <= gmode_next;
            s_int_reg     <= s_int_next;
            s_prev_reg    <= s_prev_next;
            g_int_reg     <= g_int_next;
            g_prev_reg    <= g_prev_next;
            sel_reg       <= sel_next;
            gap_go_reg    <= gap_go_next;
            wk_valid_reg  <= wk_valid_next;
            wk_mode_reg   <= wk_mode_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED_P: spd_kp_reg    <= cfg_data;
                    CFG_SPEED_I: spd_ki_reg    <= cfg_data;
                    CFG_SPEED_D: spd_kd_reg    <= cfg_data;
                    CFG_GAP_P:   gap_kp_reg    <= cfg_data;
                    CFG_GAP_I:   gap_ki_reg    <= cfg_data;
                    CFG_GAP_D:   gap_kd_reg    <= cfg_data;
                    CFG_ACCEL:   accel_lim_reg <= cfg_data[13:0];
                    default:     decel_lim_reg <= cfg_data[13:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg <= dev_next;
        e_reg   <= e_next;
        i_reg   <= i_next;
        res_reg <= res_next;
        q_reg   <= q_next;
        if (in_valid && !in_stall)
        begin
            req_reg  <= req_type;
            ego_reg  <= ego_speed;
            lead_reg <= lead_present;
            dist_reg <= lead_distance;
            rel_reg  <= lead_rel_speed;
            drv_reg  <= driver_present;
            dacc_reg <= driver_accel;
            dt_reg   <= step_time;
        end
        if (out_load)
        begin
            o_av_reg    <= wk_valid_reg;
            o_cmd_reg   <= clamp_c;
            o_mode_reg  <= wk_mode_reg;
            o_en_reg    <= en_reg;
            o_act_reg   <= act_reg;
            o_held_reg  <= held_reg;
            o_spd_reg   <= tgt_reg;
            o_gmode_reg <= gmode_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign accel_valid     = o_av_reg;
    assign accel_cmd       = o_cmd_reg;
    assign loop_mode       = o_mode_reg;
    assign is_enabled      = o_en_reg;
    assign is_active       = o_act_reg;
    assign set_speed_valid = o_held_reg;
    assign set_speed       = o_spd_reg;
    assign gap_mode        = o_gmode_reg;

endmodule
